### rtl/core/triangle_normal_color_builder_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the triangle normal and color builder
// Each macro places one labeled concurrent check on clk, held off during rst.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_NORMAL_COLOR_BUILDER_DEFINES_SVH
`define TRIANGLE_NORMAL_COLOR_BUILDER_DEFINES_SVH

// Same-cycle implication: when ante holds, cons must hold too.
`define TNCB_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the following cycle.
`define TNCB_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/tncb_pkg.sv
// ----------------------------------------------------------------------------
// tncb_pkg
// Shared constants, sequencer states and operand tables for the builder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tncb_pkg;

  localparam int COORD_WIDTH_DEF     = 32;
  localparam int COLOR_FRAC_BITS_DEF = 16;
  // Largest normalized magnitude has this many bits before the square root.
  localparam int SCALE_BITS          = 30;

  localparam logic [1:0] VTX_LAST  = 2'd2;
  localparam logic [1:0] COMP_LAST = 2'd2;
  localparam logic [2:0] PROD_LAST = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_LD,
    S_MUL,
    S_ABS,
    S_NORM,
    S_SQ_LD,
    S_SQ,
    S_SQRT,
    S_DIV_LD,
    S_DIV,
    S_OUT
  } state_t;

  // Cross product terms in order: a1*b2, a2*b1, a2*b0, a0*b2, a0*b1, a1*b0.
  // Odd terms are subtracted from the even term before them.
  function automatic logic [1:0] mul_a_sel(input logic [2:0] prod);
    logic [1:0] sel;
    case (prod)
      3'd0:    sel = 2'd1;
      3'd1:    sel = 2'd2;
      3'd2:    sel = 2'd2;
      3'd3:    sel = 2'd0;
      3'd4:    sel = 2'd0;
      3'd5:    sel = 2'd1;
      default: sel = 2'd0;
    endcase
    return sel;
  endfunction

  function automatic logic [1:0] mul_b_sel(input logic [2:0] prod);
    logic [1:0] sel;
    case (prod)
      3'd0:    sel = 2'd2;
      3'd1:    sel = 2'd1;
      3'd2:    sel = 2'd0;
      3'd3:    sel = 2'd2;
      3'd4:    sel = 2'd1;
      3'd5:    sel = 2'd0;
      default: sel = 2'd0;
    endcase
    return sel;
  endfunction

endpackage

`default_nettype wire

### rtl/core/triangle_normal_color_builder.sv
// ----------------------------------------------------------------------------
// triangle_normal_color_builder
// Collects three vertices, picks supplied or geometric normals, and emits each
// vertex with its position, normal and a color derived from the unit normal.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                 Payload
// s_        in         s_tvalid / s_tready       s_tdata: position, given normal
//                                                s_tuser: normal valid flag
// m_        out        m_tvalid / m_tready       m_tdata: position, normal, color
//                                                m_tlast: third vertex
// cfg_      in         cfg_valid / cfg_ready     cfg_data: mesh_has_normals
//
// Sequence: the first two vertices of a triangle are only stored. The third
//   starts a run on a single shift-add / subtract unit: six cross product terms
//   (not for given normals), a normalizing shift, three squares, a square root
//   and three divisions, which give the unit normal or, in the color pass, the
//   colors. A face normal gets one color pass for all three vertices; given
//   normals get a color pass per vertex.
// Reset: rst clears the sequencer, the vertex phase and the config register.
// Stalls: s_tready is low for the whole run; a result holds on m_tdata until
//   m_tready takes it. cfg_ready is always high.
//
`timescale 1ns / 1ps
`default_nettype none
`include "triangle_normal_color_builder_defines.svh"

module triangle_normal_color_builder
  import tncb_pkg::*;
#(
  parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
  parameter int COLOR_FRAC_BITS = COLOR_FRAC_BITS_DEF
) (
  input  wire                                            clk,
  input  wire                                            rst,
  // pos_x, pos_y, pos_z, given_nx, given_ny, given_nz
  input  wire                                            s_tvalid,
  output logic                                           s_tready,
  input  wire  [((6*COORD_WIDTH+7)/8)*8-1:0]             s_tdata,
  // normal_valid
  input  wire  [0:0]                                     s_tuser,
  // out_x, out_y, out_z, normal_x, normal_y, normal_z,
  // color_red, color_green, color_blue
  output logic                                           m_tvalid,
  input  wire                                            m_tready,
  output logic [((6*COORD_WIDTH+3*(COLOR_FRAC_BITS+1)+7)/8)*8-1:0] m_tdata,
  output logic                                           m_tlast,
  input  wire                                            cfg_valid,
  output logic                                           cfg_ready,
  input  wire  [0:0]                                     cfg_data
);

  localparam int CW      = COORD_WIDTH;
  localparam int CF      = COLOR_FRAC_BITS;
  localparam int NF      = CW / 2;
  localparam int SB      = SCALE_BITS;
  localparam int LW      = SB + 1;
  localparam int SQW     = 2 * SB + 2;
  localparam int W       = 2 * CW + 3;
  localparam int AW      = (W > SQW + 2) ? W : SQW + 2;
  localparam int DQ      = (NF + 1 > CF) ? NF + 1 : CF;
  localparam int MW      = (CW + 1 > SB) ? CW + 1 : SB;
  localparam int CNW     = $clog2(MW + 1);
  localparam int OUT_RAW = 6 * CW + 3 * (CF + 1);
  localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;

  localparam logic [CF:0] HALF = (CF + 1)'(1) << (CF - 1);

  state_t state, state_next;

  // Triangle storage, indexed [component][vertex].
  logic [CW-1:0]     pos [3][3];
  logic [CW-1:0]     nrm [3][3];
  logic [1:0]        phase;
  logic              nv0, nv1;
  logic              mesh_has_normals;
  logic              use_given;

  // Edge vectors v2-v0 and v1-v0.
  logic [CW:0]       da [3];
  logic [CW:0]       db [3];

  // Shared unit working registers.
  logic [AW-1:0]     acc;
  logic [AW-1:0]     mcand;
  logic [MW-1:0]     mplier;
  logic              mneg;
  logic [AW-1:0]     mvec [3];
  logic [2:0]        wneg;
  logic [SQW-1:0]    root;
  logic [SQW-1:0]    sbit;
  logic [LW-1:0]     rem;
  logic [DQ-1:0]     dlow;
  logic [DQ-1:0]     q;
  logic [CF:0]       col [3];

  logic [1:0]        vtx;
  logic [1:0]        k;
  logic [2:0]        prod;
  logic [CNW-1:0]    cnt;
  logic              color_pass;

  // Input unpack.
  logic [CW-1:0]     in_pos [3];
  logic [CW-1:0]     in_gn [3];
  logic              use_given_in;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      in_pos[c] = s_tdata[c*CW +: CW];
      in_gn[c]  = s_tdata[(c+3)*CW +: CW];
    end
  end

  assign use_given_in = mesh_has_normals & nv0 & nv1 & s_tuser[0];

  // Operand selection.
  logic [1:0]        ia, ib;
  logic [CW:0]       da_sel, db_sel, da_mag, db_mag;
  logic [SB-1:0]     u_sel;
  logic [CW-1:0]     out_n [3];
  logic [AW-1:0]     abs_src, abs_mag;
  logic [SQW-1:0]    trial_sq;
  logic [LW:0]       trial_div;

  assign ia     = mul_a_sel(prod);
  assign ib     = mul_b_sel(prod);
  assign da_sel = da[ia];
  assign db_sel = db[ib];
  assign da_mag = da_sel[CW] ? (~da_sel + (CW + 1)'(1)) : da_sel;
  assign db_mag = db_sel[CW] ? (~db_sel + (CW + 1)'(1)) : db_sel;
  assign u_sel  = mvec[k][AW-1 -: SB];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      out_n[c] = nrm[c][vtx];
    end
  end

  assign abs_src   = color_pass ? {{(AW - CW){out_n[k][CW-1]}}, out_n[k]} : mvec[k];
  assign trial_sq  = root | sbit;
  assign trial_div = {rem, dlow[DQ-1]};

  // The one adder / subtractor that the multiply, absolute value, square root and divide steps run through.
  logic [AW-1:0]     alu_a, alu_b;
  logic              alu_sub;
  logic [AW:0]       alu_sum;
  logic              alu_c;

  always_comb begin
    alu_a   = acc;
    alu_b   = mcand;
    alu_sub = 1'b0;
    case (state)
      S_MUL: begin
        alu_sub = mneg;
      end
      S_ABS: begin
        alu_a   = '0;
        alu_b   = abs_src;
        alu_sub = 1'b1;
      end
      S_SQRT: begin
        alu_b   = AW'(trial_sq);
        alu_sub = 1'b1;
      end
      S_DIV_LD: begin
        alu_a = color_pass ? (AW'(u_sel) << (CF - 1)) : (AW'(u_sel) << NF);
        alu_b = AW'(root[LW-1:1]);
      end
      S_DIV: begin
        alu_a   = AW'(trial_div);
        alu_b   = AW'(root[LW-1:0]);
        alu_sub = 1'b1;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b ^ {AW{alu_sub}}} + (AW + 1)'(alu_sub);
  assign alu_c   = alu_sum[AW];
  assign abs_mag = abs_src[AW-1] ? alu_sum[AW-1:0] : abs_src;

  // Step results and loop ends.
  logic [AW-1:0]     acc_step;
  logic [AW-1:0]     mvec_or;
  logic              norm_zero, norm_done;
  logic              mul_last, sq_last, sqrt_last, div_last;
  logic [DQ-1:0]     q_fin;
  logic [CW-1:0]     q_n, n_val;
  logic [CF:0]       t_val, col_val;

  assign acc_step  = mplier[0] ? alu_sum[AW-1:0] : acc;
  assign mvec_or   = mvec[0] | mvec[1] | mvec[2];
  assign norm_zero = ~|mvec_or;
  assign norm_done = mvec_or[AW-1];
  assign mul_last  = (cnt == CNW'(CW));
  assign sq_last   = (cnt == CNW'(SB - 1));
  assign sqrt_last = (cnt == CNW'(SB));
  assign div_last  = color_pass ? (cnt == CNW'(CF - 1)) : (cnt == CNW'(NF));
  assign q_fin     = {q[DQ-2:0], alu_c};
  assign q_n       = CW'(q_fin);
  assign n_val     = wneg[k] ? (~q_n + CW'(1)) : q_n;
  assign t_val     = (q_fin > DQ'(HALF)) ? HALF : (CF + 1)'(q_fin);
  assign col_val   = wneg[k] ? (HALF - t_val) : (HALF + t_val);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid && phase == VTX_LAST) begin
          state_next = use_given_in ? S_ABS : S_MUL_LD;
        end
      end
      S_MUL_LD: state_next = S_MUL;
      S_MUL: begin
        if (mul_last) begin
          state_next = (prod == PROD_LAST) ? S_ABS : S_MUL_LD;
        end
      end
      S_ABS: begin
        if (k == COMP_LAST) begin
          state_next = S_NORM;
        end
      end
      S_NORM: begin
        if (norm_zero) begin
          state_next = color_pass ? S_OUT : S_ABS;
        end else if (norm_done) begin
          state_next = S_SQ_LD;
        end
      end
      S_SQ_LD: state_next = S_SQ;
      S_SQ: begin
        if (sq_last) begin
          state_next = (k == COMP_LAST) ? S_SQRT : S_SQ_LD;
        end
      end
      S_SQRT: begin
        if (sqrt_last) begin
          state_next = S_DIV_LD;
        end
      end
      S_DIV_LD: state_next = S_DIV;
      S_DIV: begin
        if (div_last) begin
          if (k == COMP_LAST) begin
            state_next = color_pass ? S_OUT : S_ABS;
          end else begin
            state_next = S_DIV_LD;
          end
        end
      end
      S_OUT: begin
        if (m_tready) begin
          if (vtx == VTX_LAST) begin
            state_next = S_IDLE;
          end else begin
            state_next = use_given ? S_ABS : S_OUT;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= '0;
      mesh_has_normals <= 1'b0;
    end else begin
      if (cfg_valid) begin
        mesh_has_normals <= cfg_data[0];
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            // Store the vertex; the third one also forms the edge vectors.
            for (int c = 0; c < 3; c++) begin
              pos[c][phase] <= in_pos[c];
              nrm[c][phase] <= in_gn[c];
            end
            if (phase == 2'd0) begin
              nv0 <= s_tuser[0];
            end
            if (phase == 2'd1) begin
              nv1 <= s_tuser[0];
            end
            if (phase == VTX_LAST) begin
              phase <= '0;
              for (int c = 0; c < 3; c++) begin
                da[c] <= {in_pos[c][CW-1], in_pos[c]} - {pos[c][0][CW-1], pos[c][0]};
                db[c] <= {pos[c][1][CW-1], pos[c][1]} - {pos[c][0][CW-1], pos[c][0]};
              end
              use_given  <= use_given_in;
              color_pass <= use_given_in;
              vtx        <= '0;
              k          <= '0;
              prod       <= '0;
            end else begin
              phase <= phase + 2'd1;
            end
          end
        end
        S_MUL_LD: begin
          mcand  <= AW'(da_mag);
          mplier <= MW'(db_mag);
          mneg   <= da_sel[CW] ^ db_sel[CW] ^ prod[0];
          if (!prod[0]) begin
            acc <= '0;
          end
          cnt <= '0;
        end
        S_MUL, S_SQ: begin
          acc    <= acc_step;
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          // Restart the count for the square root after the last square.
          if (state == S_SQ && sq_last && k == COMP_LAST) begin
            cnt <= '0;
          end else begin
            cnt <= cnt + CNW'(1);
          end
          if (state == S_MUL && mul_last) begin
            if (prod[0]) begin
              mvec[prod[2:1]] <= acc_step;
            end
            prod <= prod + 3'd1;
          end
          if (state == S_SQ && sq_last) begin
            k <= (k == COMP_LAST) ? 2'd0 : k + 2'd1;
            if (k == COMP_LAST) begin
              root <= '0;
              sbit <= SQW'(1) << (2 * SB);
            end
          end
        end
        S_ABS: begin
          // Store magnitudes; a normal goes in left-aligned to shorten the shift.
          mvec[k] <= color_pass ? {abs_mag[CW-1:0], {(AW - CW){1'b0}}} : abs_mag;
          wneg[k] <= abs_src[AW-1];
          k       <= (k == COMP_LAST) ? 2'd0 : k + 2'd1;
        end
        S_NORM: begin
          if (norm_zero) begin
            if (!color_pass) begin
              for (int c = 0; c < 3; c++) begin
                for (int v = 0; v < 3; v++) begin
                  nrm[c][v] <= '0;
                end
              end
              color_pass <= 1'b1;
              vtx        <= '0;
              k          <= '0;
            end else begin
              for (int c = 0; c < 3; c++) begin
                col[c] <= HALF;
              end
            end
          end else if (!norm_done) begin
            for (int c = 0; c < 3; c++) begin
              mvec[c] <= mvec[c] << 1;
            end
          end else begin
            k <= '0;
          end
        end
        S_SQ_LD: begin
          mcand  <= AW'(u_sel);
          mplier <= MW'(u_sel);
          if (k == 2'd0) begin
            acc <= '0;
          end
          cnt <= '0;
        end
        S_SQRT: begin
          if (alu_c) begin
            acc  <= alu_sum[AW-1:0];
            root <= (root >> 1) | sbit;
          end else begin
            root <= root >> 1;
          end
          sbit <= sbit >> 2;
          cnt  <= cnt + CNW'(1);
        end
        S_DIV_LD: begin
          // Dividend is the scaled magnitude plus half the length, for rounding.
          rem  <= color_pass ? LW'(alu_sum[AW-1:0] >> CF) : LW'(alu_sum[AW-1:0] >> (NF + 1));
          dlow <= color_pass ? (DQ'(alu_sum) << (DQ - CF)) : (DQ'(alu_sum) << (DQ - NF - 1));
          q    <= '0;
          cnt  <= '0;
        end
        S_DIV: begin
          rem  <= alu_c ? LW'(alu_sum) : LW'(trial_div);
          dlow <= dlow << 1;
          q    <= q_fin;
          cnt  <= cnt + CNW'(1);
          if (div_last) begin
            if (!color_pass) begin
              for (int v = 0; v < 3; v++) begin
                nrm[k][v] <= n_val;
              end
            end else begin
              col[k] <= col_val;
            end
            k <= (k == COMP_LAST) ? 2'd0 : k + 2'd1;
            if (k == COMP_LAST && !color_pass) begin
              color_pass <= 1'b1;
              vtx        <= '0;
            end
          end
        end
        S_OUT: begin
          // Advance to the next vertex; face-normal colors carry over unchanged.
          if (m_tready) begin
            vtx <= (vtx == VTX_LAST) ? 2'd0 : vtx + 2'd1;
            k   <= '0;
          end
        end
        default: begin
          k <= '0;
        end
      endcase
    end
  end

  // Ports.
  logic [OUT_RAW-1:0] out_raw;

  assign out_raw = {col[2], col[1], col[0], out_n[2], out_n[1], out_n[0],
                    pos[2][vtx], pos[1][vtx], pos[0][vtx]};

  assign s_tready  = (state == S_IDLE);
  assign m_tvalid  = (state == S_OUT);
  assign m_tdata   = OUT_W'(out_raw);
  assign m_tlast   = (vtx == VTX_LAST);
  assign cfg_ready = 1'b1;

  // Checks.
  `TNCB_CHECK(a_no_overlap, m_tvalid, !s_tready, "input taken while a result waits")
  `TNCB_CHECK(a_phase_range, 1'b1, phase != 2'd3, "vertex phase out of range")
  `TNCB_CHECK(a_sqrt_bit, state == S_SQRT, $onehot(sbit), "square root bit lost")
  `TNCB_CHECK_NEXT(a_last_idle, m_tvalid && m_tready && m_tlast, s_tready,
                   "not idle after the third vertex")

endmodule

`default_nettype wire
